FILE: rtl/dpd_pkg.sv
// Package for the dictionary phrase decoder: sizes, phase and status codes.
// No dependencies; used by every module of the block.
`default_nettype none
package dpd_pkg;
    localparam int MaxPhrases    = 256;
    localparam int MaxPhraseLen  = 32;
    localparam int VarintMaxByte = 10;
    localparam int HdrLen        = 7;
    localparam int IdxW          = $clog2(MaxPhrases);
    localparam int OffW          = $clog2(MaxPhraseLen);
    localparam int LenW          = $clog2(MaxPhraseLen + 1);
    localparam int AddrW         = IdxW + OffW;

    localparam logic [7:0] MagicA     = 8'h44;
    localparam logic [7:0] MagicB     = 8'h54;
    localparam logic [7:0] FmtVersion = 8'h01;

    localparam logic [1:0] ModeRecord = 2'd0;
    localparam logic [1:0] ModeByte   = 2'd1;
    localparam logic [1:0] ModeLength = 2'd2;

    localparam logic [1:0] RegDictId = 2'd0;
    localparam logic [1:0] RegCount  = 2'd1;
    localparam logic [1:0] RegMaxOut = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_CODE   = 3'd2,
        PH_RUNLEN = 3'd3,
        PH_RUN    = 3'd4,
        PH_ERROR  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_HEADER = 3'd1,
        ST_ID     = 3'd2,
        ST_VARINT = 3'd3,
        ST_RUN    = 3'd4,
        ST_CODE   = 3'd5,
        ST_LIMIT  = 3'd6,
        ST_LENGTH = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EMIT,
        S_STAT
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/dictionary_phrase_decoder.sv
// Dictionary phrase decoder top level: APB registers, record parser, expander.
// Any byte other than a phrase code is handled in S_IDLE. A phrase code goes through S_LOOK
// (length read), then S_EMIT with one memory read per phrase byte. record_last on a literal or a
// phrase code adds an S_STAT status beat; on other bytes the status leaves with the byte.
// One input item in flight at a time; the output register holds one beat, and a held
// beat stalls the input. Reset (synchronous, active low) clears registers and parser.
`default_nettype none
module dictionary_phrase_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_phrase_index,
    input  wire logic [4:0]  i_phrase_offset,
    input  wire logic [5:0]  i_phrase_length,
    input  wire logic        i_record_last,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic        o_kind,
    output      logic [7:0]  o_out_byte,
    output      logic [2:0]  o_status,
    output      logic        o_end_of_run
);
    import dpd_pkg::*;

    // configuration registers
    logic [31:0] r_dict_id, r_max_out;
    logic [8:0]  r_count;
    logic [1:0]  cfg_reg;
    assign cfg_reg = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dict_id <= '0;
            r_count   <= 9'd1;
            r_max_out <= '1;
        end else if (psel && penable && pwrite) begin
            case (cfg_reg)
                RegDictId: r_dict_id <= pwdata;
                RegCount:  r_count   <= pwdata[8:0];
                RegMaxOut: r_max_out <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_reg)
            RegDictId: prdata = r_dict_id;
            RegCount:  prdata = {23'd0, r_count};
            RegMaxOut: prdata = r_max_out;
            default:   prdata = '0;
        endcase
    end

    // parser state
    t_phase       r_phase, n_phase;
    logic [2:0]   r_hcnt, n_hcnt;
    logic [31:0]  r_id, n_id;
    logic [63:0]  r_vval, n_vval;
    logic [3:0]   r_vsh, n_vsh;
    logic [31:0]  r_decl, n_decl;
    logic [32:0]  r_prod, n_prod;
    logic [32:0]  r_run, n_run;
    t_status      r_err, n_err;
    t_state       r_state, n_state;
    logic         r_last, n_last;
    logic [IdxW-1:0] r_pidx, n_pidx;
    logic [LenW-1:0] r_plen, n_plen;
    logic [LenW-1:0] r_pos, n_pos;

    // output register
    logic        r_ovalid, n_ovalid;
    logic        r_kind, n_kind;
    logic [7:0]  r_obyte, n_obyte;
    logic [2:0]  r_ostat, n_ostat;
    logic        r_eor, n_eor;

    logic [7:0]      bq;
    logic [LenW-1:0] lq;
    logic            out_free;
    logic            take;
    logic            bwe, lwe;
    logic            close_rec;
    logic [AddrW-1:0] rd_addr;

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign take     = i_valid && o_ready;
    assign bwe = take && i_mode == ModeByte;
    assign lwe = take && i_mode == ModeLength;

    // read the byte at the next position while the current one is sent
    always_comb begin
        rd_addr = {r_pidx, r_pos[OffW-1:0]};
        if (r_state == S_LOOK) begin
            rd_addr = {r_pidx, {OffW{1'b0}}};
        end else if (r_state == S_EMIT && out_free) begin
            rd_addr = {r_pidx, OffW'(r_pos + LenW'(1))};
        end
    end

    dpd_store u_store (
        .i_clk    (i_clk),
        .i_bwe    (bwe),
        .i_baddr_w({i_phrase_index, i_phrase_offset}),
        .i_bdata  (i_data_byte),
        .i_baddr_r(rd_addr),
        .o_bq     (bq),
        .i_lwe    (lwe),
        .i_laddr_w(i_phrase_index),
        .i_ldata  ((i_phrase_length > LenW'(MaxPhraseLen)) ? LenW'(MaxPhraseLen)
                                                            : i_phrase_length),
        .i_laddr_r(n_pidx),
        .o_lq     (lq)
    );

    // varint step on the incoming byte
    logic [63:0] grp_sh;
    logic [6:0]  sh;
    logic        v_err, v_done;
    logic [63:0] v_new;
    logic [63:0] v_fit;
    logic [63:0] room;
    logic [2:0]  fin_stat;

    assign room = 64'(r_max_out) - 64'(r_prod);

    always_comb begin
        sh     = 7'(r_vsh) * 7'd7;
        grp_sh = {57'd0, i_data_byte[6:0]} << sh[5:0];
        v_fit  = 64'(i_data_byte[6:0]) >> (7'd64 - sh);
        v_err  = (r_vsh >= 4'(VarintMaxByte)) || (sh >= 7'd64) ||
                 ((sh > 7'd57) && (v_fit != 64'd0));
        v_new  = r_vval | grp_sh;
        v_done = !i_data_byte[7];
        if (i_data_byte[7] && (r_vsh + 4'd1 >= 4'(VarintMaxByte))) begin
            v_err = 1'b1;
        end
    end

    // closing status, taken from the parser state after this cycle's byte
    always_comb begin
        case (n_phase)
            PH_ERROR:  fin_stat = n_err;
            PH_HEADER: fin_stat = ST_HEADER;
            PH_LENGTH, PH_RUNLEN: fin_stat = ST_VARINT;
            PH_RUN:    fin_stat = ST_RUN;
            default: begin
                if (n_vsh != 4'd0) fin_stat = ST_VARINT;
                else if (n_prod != {1'b0, n_decl}) fin_stat = ST_LENGTH;
                else fin_stat = ST_OK;
            end
        endcase
    end

    // next state of the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take && i_mode == ModeRecord) begin
                    if (r_phase == PH_CODE && !v_err && v_done && v_new != 64'd0
                        && v_new <= 64'(r_count > 9'(MaxPhrases) ? 9'(MaxPhrases)
                                                                 : r_count)) begin
                        n_state = S_LOOK;
                    end else if (i_record_last && r_phase == PH_RUN) begin
                        n_state = S_STAT;
                    end
                end
            end
            S_LOOK: begin
                if (LenW'(lq) > LenW'(MaxPhraseLen) ||
                    64'(lq) > room) n_state = r_last ? S_STAT : S_IDLE;
                else if (lq == '0) n_state = r_last ? S_STAT : S_IDLE;
                else n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free && r_pos + LenW'(1) == r_plen) begin
                    n_state = r_last ? S_STAT : S_IDLE;
                end
            end
            S_STAT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase = r_phase; n_hcnt = r_hcnt; n_id = r_id; n_vval = r_vval;
        n_vsh = r_vsh; n_decl = r_decl; n_prod = r_prod; n_run = r_run;
        n_err = r_err; n_last = r_last; n_pidx = r_pidx; n_plen = r_plen;
        n_pos = r_pos;
        n_ovalid = r_ovalid && !i_ready;
        n_kind = r_kind; n_obyte = r_obyte; n_ostat = r_ostat; n_eor = r_eor;
        close_rec = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (take && i_mode == ModeRecord) begin
                    n_last = i_record_last;
                    case (r_phase)
                        PH_HEADER: begin
                            if ((r_hcnt == 3'd0 && i_data_byte != MagicA) ||
                                (r_hcnt == 3'd1 && i_data_byte != MagicB) ||
                                (r_hcnt == 3'd2 && i_data_byte != FmtVersion)) begin
                                n_phase = PH_ERROR; n_err = ST_HEADER;
                            end else begin
                                if (r_hcnt >= 3'd3)
                                    n_id = r_id | (32'(i_data_byte)
                                           << {r_hcnt[1:0] - 2'd3, 3'd0});
                                n_hcnt = r_hcnt + 3'd1;
                                if (n_hcnt == 3'(HdrLen)) begin
                                    if (n_id != r_dict_id) begin
                                        n_phase = PH_ERROR; n_err = ST_ID;
                                    end else begin
                                        n_phase = PH_LENGTH;
                                        n_vval = '0; n_vsh = '0;
                                    end
                                end
                            end
                        end
                        PH_LENGTH, PH_CODE, PH_RUNLEN: begin
                            if (v_err) begin
                                n_phase = PH_ERROR; n_err = ST_VARINT;
                            end else if (!v_done) begin
                                n_vval = v_new; n_vsh = r_vsh + 4'd1;
                            end else begin
                                n_vval = '0; n_vsh = '0;
                                if (r_phase == PH_LENGTH) begin
                                    if (v_new > 64'(r_max_out)) begin
                                        n_phase = PH_ERROR; n_err = ST_LIMIT;
                                    end else begin
                                        n_decl = v_new[31:0]; n_phase = PH_CODE;
                                    end
                                end else if (r_phase == PH_RUNLEN) begin
                                    if (v_new > room) begin
                                        n_phase = PH_ERROR; n_err = ST_LIMIT;
                                    end else begin
                                        n_run = v_new[32:0];
                                        n_phase = (v_new == 64'd0) ? PH_CODE : PH_RUN;
                                    end
                                end else if (v_new == 64'd0) begin
                                    n_phase = PH_RUNLEN;
                                end else if (v_new > 64'(r_count > 9'(MaxPhrases)
                                                          ? 9'(MaxPhrases) : r_count)) begin
                                    n_phase = PH_ERROR; n_err = ST_CODE;
                                end else begin
                                    n_pidx = IdxW'(v_new - 64'd1);
                                end
                            end
                        end
                        PH_RUN: begin
                            n_ovalid = 1'b1; n_kind = 1'b0; n_obyte = i_data_byte;
                            n_ostat = ST_OK; n_eor = !i_record_last;
                            n_prod = r_prod + 33'd1; n_run = r_run - 33'd1;
                            if (n_run == 33'd0) n_phase = PH_CODE;
                        end
                        default: ;
                    endcase
                    // status goes out now unless a data beat takes this cycle
                    if (i_record_last && r_phase != PH_RUN && n_state == S_IDLE) begin
                        n_ovalid = 1'b1; n_kind = 1'b1; n_obyte = '0; n_eor = 1'b1;
                        close_rec = 1'b1;
                    end
                end
            end
            S_LOOK: begin
                n_plen = lq; n_pos = '0;
                if (64'(lq) > room) begin
                    n_phase = PH_ERROR; n_err = ST_LIMIT;
                end else begin
                    n_prod = r_prod + 33'(lq);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_kind = 1'b0; n_obyte = bq; n_ostat = ST_OK;
                    n_eor = !r_last && (r_pos + LenW'(1) == r_plen);
                    n_pos = r_pos + LenW'(1);
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_kind = 1'b1; n_obyte = '0; n_eor = 1'b1;
                    close_rec = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_phase <= PH_HEADER; r_hcnt <= '0; r_id <= '0;
            r_vval <= '0; r_vsh <= '0; r_decl <= '0; r_prod <= '0; r_run <= '0;
            r_err <= ST_OK; r_last <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_last <= n_last; r_ovalid <= n_ovalid;
            if (close_rec) begin
                // status beat is loaded: restart the parser for the next record
                r_phase <= PH_HEADER; r_hcnt <= '0; r_id <= '0; r_vval <= '0;
                r_vsh <= '0; r_decl <= '0; r_prod <= '0; r_run <= '0; r_err <= ST_OK;
            end else begin
                r_phase <= n_phase; r_hcnt <= n_hcnt; r_id <= n_id; r_vval <= n_vval;
                r_vsh <= n_vsh; r_decl <= n_decl; r_prod <= n_prod; r_run <= n_run;
                r_err <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx; r_plen <= n_plen; r_pos <= n_pos;
        r_kind <= n_kind; r_obyte <= n_obyte;
        r_ostat <= close_rec ? fin_stat : n_ostat;
        r_eor <= n_eor;
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_kind;
    assign o_out_byte   = r_obyte;
    assign o_status     = r_ostat;
    assign o_end_of_run = r_eor;
endmodule
`default_nettype wire

FILE: rtl/dpd_store.sv
// Phrase store: byte memory and length memory, registered reads.
// Depends on dpd_pkg.
`default_nettype none
module dpd_store (
    input  wire logic                   i_clk,
    input  wire logic                   i_bwe,
    input  wire logic [dpd_pkg::AddrW-1:0] i_baddr_w,
    input  wire logic [7:0]             i_bdata,
    input  wire logic [dpd_pkg::AddrW-1:0] i_baddr_r,
    output      logic [7:0]             o_bq,
    input  wire logic                   i_lwe,
    input  wire logic [dpd_pkg::IdxW-1:0] i_laddr_w,
    input  wire logic [dpd_pkg::LenW-1:0] i_ldata,
    input  wire logic [dpd_pkg::IdxW-1:0] i_laddr_r,
    output      logic [dpd_pkg::LenW-1:0] o_lq
);
    import dpd_pkg::*;
    logic [7:0]      r_bytes [MaxPhrases*MaxPhraseLen];
    logic [LenW-1:0] r_lens  [MaxPhrases];

    always_ff @(posedge i_clk) begin
        if (i_bwe) begin
            r_bytes[i_baddr_w] <= i_bdata;
        end
        o_bq <= r_bytes[i_baddr_r];
    end

    always_ff @(posedge i_clk) begin
        if (i_lwe) begin
            r_lens[i_laddr_w] <= i_ldata;
        end
        o_lq <= r_lens[i_laddr_r];
    end
endmodule
`default_nettype wire

FILE: tb/dictionary_phrase_decoder_test.sv
// Self-checking testbench for the dictionary phrase decoder: APB setup, record streams,
// phrase loads, output scoreboard. Depends on rtl/dpd_pkg.sv and the decoder top level.
`default_nettype none
module dictionary_phrase_decoder_test;
    import dpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       eor;
    } t_beat;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] data;
        logic [7:0] pidx;
        logic [4:0] poff;
        logic [5:0] plen;
        logic       last;
        logic       has_exp;
        t_status    exp_st;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = '0;
    logic [7:0]  i_data_byte = '0, i_phrase_index = '0;
    logic [4:0]  i_phrase_offset = '0;
    logic [5:0]  i_phrase_length = '0;
    logic        i_record_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_kind;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_status;
    logic        o_end_of_run;

    dictionary_phrase_decoder dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the decoder: configuration, phrase store, parser state.
    logic [31:0] m_dict_id = 0;
    logic [8:0]  m_count = 1;
    logic [31:0] m_max_out = 32'hFFFF_FFFF;
    logic [7:0]  m_bytes [MaxPhrases*MaxPhraseLen];
    logic [5:0]  m_lens [MaxPhrases];
    bit          m_len_set [MaxPhrases];
    t_phase      m_phase;
    int unsigned m_hdr;
    logic [31:0] m_id;
    logic [63:0] m_vval;
    int unsigned m_vpos;
    logic [31:0] m_decl;
    logic [32:0] m_made, m_run;
    t_status     m_err;

    t_beat expected_beats[$];
    int    fail_count = 0;
    int    idle_pct = 0, stall_pct = 0;
    bit    hold_off = 1'b0;

    task automatic report(input string what);
        fail_count++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    function automatic void clear_parse();
        m_phase = PH_HEADER; m_hdr = 0; m_id = 0; m_vval = 0; m_vpos = 0;
        m_decl = 0; m_made = 0; m_run = 0; m_err = ST_OK;
    endfunction

    function automatic void push_beat(input logic k, input logic [7:0] b, input t_status s);
        t_beat e;
        e.kind = k; e.out_byte = b; e.status = s; e.eor = 1'b0;
        expected_beats.push_back(e);
    endfunction

    function automatic void abort(input t_status s);
        m_err = s; m_phase = PH_ERROR;
    endfunction

    // Feed one varint byte: 0 more, 1 done, -1 malformed.
    function automatic int gather_varint(input logic [7:0] b);
        int unsigned sh;
        logic [63:0] grp;
        sh = 7 * m_vpos;
        grp = {57'd0, b[6:0]};
        if (m_vpos >= VarintMaxByte || sh >= 64) return -1;
        if (sh + 7 > 64 && (grp >> (64 - sh)) != 0) return -1;
        m_vval |= grp << sh;
        m_vpos++;
        if (b[7]) return (m_vpos >= VarintMaxByte) ? -1 : 0;
        return 1;
    endfunction

    function automatic void decode_record_byte(input logic [7:0] b);
        int r;
        logic [63:0] v;
        logic [63:0] room;
        int unsigned lim, idx, len;
        room = {32'd0, m_max_out} - {31'd0, m_made};
        case (m_phase)
            PH_HEADER: begin
                if ((m_hdr == 0 && b != MagicA) || (m_hdr == 1 && b != MagicB) ||
                    (m_hdr == 2 && b != FmtVersion)) begin
                    abort(ST_HEADER);
                end else begin
                    if (m_hdr >= 3) m_id |= {24'd0, b} << (8 * ((m_hdr - 3) & 3));
                    m_hdr++;
                    if (m_hdr >= HdrLen) begin
                        if (m_id != m_dict_id) abort(ST_ID);
                        else begin
                            m_phase = PH_LENGTH; m_vval = 0; m_vpos = 0;
                        end
                    end
                end
            end
            PH_LENGTH, PH_CODE, PH_RUNLEN: begin
                r = gather_varint(b);
                if (r < 0) abort(ST_VARINT);
                else if (r == 1) begin
                    v = m_vval; m_vval = 0; m_vpos = 0;
                    if (m_phase == PH_LENGTH) begin
                        if (v > {32'd0, m_max_out}) abort(ST_LIMIT);
                        else begin
                            m_decl = v[31:0]; m_phase = PH_CODE;
                        end
                    end else if (m_phase == PH_RUNLEN) begin
                        if (v > room) abort(ST_LIMIT);
                        else begin
                            m_run = v[32:0];
                            m_phase = (v == 0) ? PH_CODE : PH_RUN;
                        end
                    end else if (v == 0) begin
                        m_phase = PH_RUNLEN;
                    end else begin
                        lim = (m_count > MaxPhrases) ? MaxPhrases : 32'(m_count);
                        if (v > lim) abort(ST_CODE);
                        else begin
                            idx = 32'(v - 1);
                            len = 32'(m_lens[idx]);
                            if (len > MaxPhraseLen) len = MaxPhraseLen;
                            if (len > room) abort(ST_LIMIT);
                            else begin
                                for (int i = 0; i < len; i++)
                                    push_beat(1'b0, m_bytes[idx*MaxPhraseLen+i], ST_OK);
                                m_made += 33'(len);
                            end
                        end
                    end
                end
            end
            PH_RUN: begin
                push_beat(1'b0, b, ST_OK);
                m_made++; m_run--;
                if (m_run == 0) m_phase = PH_CODE;
            end
            default: ;
        endcase
    endfunction

    function automatic t_status closing_status();
        case (m_phase)
            PH_ERROR:            return m_err;
            PH_HEADER:           return ST_HEADER;
            PH_LENGTH, PH_RUNLEN: return ST_VARINT;
            PH_RUN:              return ST_RUN;
            default: begin
                if (m_vpos != 0) return ST_VARINT;
                if (m_made != {1'b0, m_decl}) return ST_LENGTH;
                return ST_OK;
            end
        endcase
    endfunction

    // Predict the beats caused by one accepted input item.
    function automatic void predict_item(input t_row it);
        int prior;
        prior = expected_beats.size();
        if (it.mode == ModeByte) begin
            m_bytes[it.pidx*MaxPhraseLen + it.poff] = it.data;
        end else if (it.mode == ModeLength) begin
            m_lens[it.pidx] = (it.plen > MaxPhraseLen) ? 6'(MaxPhraseLen) : it.plen;
            m_len_set[it.pidx] = 1'b1;
        end else if (it.mode == ModeRecord) begin
            decode_record_byte(it.data);
            if (it.last) begin
                push_beat(1'b1, 8'd0, closing_status());
                clear_parse();
            end
            if (expected_beats.size() > prior)
                expected_beats[expected_beats.size()-1].eor = 1'b1;
        end
    endfunction

    // Output side: random stall, plus the long hold-off when asked.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Scoreboard: compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_beat got, e;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_kind, o_out_byte, o_status, o_end_of_run};
            if (expected_beats.size() == 0) begin
                report($sformatf("unexpected beat %h", got));
            end else begin
                e = expected_beats.pop_front();
                if (got.kind != e.kind) report($sformatf("kind %0d exp %0d", got.kind, e.kind));
                if (got.out_byte != e.out_byte)
                    report($sformatf("byte %h exp %h", got.out_byte, e.out_byte));
                if (got.status != e.status)
                    report($sformatf("status %0d exp %0d", got.status, e.status));
                if (got.eor != e.eor) report($sformatf("end_of_run %0d exp %0d", got.eor, e.eor));
            end
        end
    end

    // Setup and access phases, then the bus goes idle before the task returns, so writes never overlap.
    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (reg_idx)
            RegDictId: m_dict_id = value;
            RegCount:  m_count = value[8:0];
            default:   m_max_out = value;
        endcase
        @(posedge i_clk);
    endtask

    // Drive one beat and hold it until accepted; predict at acceptance.
    task automatic send_item(input t_row it);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= it.mode; i_data_byte <= it.data; i_phrase_index <= it.pidx;
        i_phrase_offset <= it.poff; i_phrase_length <= it.plen; i_record_last <= it.last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_item(it);
    endtask

    // Drain: drop valid, wait for every expectation, then let the block settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_row rec(input logic [7:0] b, input logic last = 1'b0);
        t_row r;
        r = '{ModeRecord, b, 8'($urandom), 5'($urandom), 6'($urandom), last, 1'b0, ST_OK};
        return r;
    endfunction

    // Closing row of a record, with its status typed in directly.
    function automatic t_row rec_st(input logic [7:0] b, input t_status s);
        t_row r;
        r = rec(b, 1'b1);
        r.has_exp = 1'b1; r.exp_st = s;
        return r;
    endfunction

    function automatic t_row wr_byte(input int idx, input int off, input logic [7:0] b);
        t_row r;
        r = '{ModeByte, b, idx[7:0], off[4:0], 6'($urandom), 1'($urandom), 1'b0, ST_OK};
        return r;
    endfunction

    function automatic t_row wr_len(input int idx, input logic [5:0] l);
        t_row r;
        r = '{ModeLength, 8'($urandom), idx[7:0], 5'($urandom), l, 1'($urandom), 1'b0,
              ST_OK};
        return r;
    endfunction

    task automatic send_checked(input t_row it);
        if (it.has_exp) begin
            // The closing status is known without the shadow model.
            send_item(it);
            if (expected_beats.size() != 0 &&
                expected_beats[expected_beats.size()-1].status != it.exp_st)
                report($sformatf("directed row expects status %0d", it.exp_st));
        end else begin
            send_item(it);
        end
    endtask

    task automatic load_phrase(input int idx, input int len);
        for (int i = 0; i < len; i++) send_item(wr_byte(idx, i, 8'($urandom)));
        send_item(wr_len(idx, 6'(len)));
    endtask

    // Build a record: header, declared length and a mix of runs and phrase codes.
    task automatic send_record(input bit well_formed, input int loaded);
        t_row q[$];
        logic [31:0] id;
        int total, ntok, code, rl;
        id = well_formed ? m_dict_id : ($urandom_range(3) == 0 ? $urandom : m_dict_id);
        q.push_back(rec(MagicA)); q.push_back(rec(MagicB)); q.push_back(rec(FmtVersion));
        for (int i = 0; i < 4; i++) q.push_back(rec(id[8*i +: 8]));
        total = 0;
        ntok = $urandom_range(4);
        // Declared length is patched in below once the tokens are known.
        for (int t = 0; t < ntok; t++) begin
            if ($urandom_range(1) == 0 && loaded > 0) begin
                code = $urandom_range(loaded, 1);
                if (!m_len_set[code-1]) code = 1;
                q.push_back(rec(8'(code)));
                total += m_lens[code-1];
            end else begin
                rl = $urandom_range(5);
                q.push_back(rec(8'd0)); q.push_back(rec(8'(rl)));
                for (int i = 0; i < rl; i++) q.push_back(rec(8'($urandom)));
                total += rl;
            end
        end
        if (!well_formed) begin
            case ($urandom_range(3))
                0: total += 1;
                1: if (q.size() > 8) q = q[0:$urandom_range(q.size()-1, 7)];
                2: q.push_back(rec(8'h80));
                default: q[$urandom_range(q.size()-1)].data = 8'($urandom);
            endcase
        end
        // Two-byte LEB128 length when it does not fit in seven bits.
        if (total < 128) q.insert(7, rec(8'(total)));
        else begin
            q.insert(7, rec(8'(total >> 7)));
            q.insert(7, rec(8'(total | 8'h80)));
        end
        q[q.size()-1].last = 1'b1;
        foreach (q[i]) send_item(q[i]);
    endtask

    initial begin
        #20_000_000;
        $display("dictionary_phrase_decoder_test: FAIL");
        $finish;
    end

    initial begin
        t_row dir[$];
        int items;
        clear_parse();
        for (int i = 0; i < MaxPhrases; i++) begin
            m_len_set[i] = 1'b0; m_lens[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: phrase 0 at full length, extremes of every field, header and id errors.
        load_phrase(0, MaxPhraseLen);
        dir.push_back(wr_len(255, 6'd63));
        dir.push_back(wr_byte(255, 31, 8'hFF));
        dir.push_back('{2'd3, 8'hFF, 8'hFF, 5'h1F, 6'h3F, 1'b1, 1'b0, ST_OK});
        dir.push_back(rec_st(8'h00, ST_HEADER));
        dir.push_back(rec_st(MagicA, ST_HEADER));
        dir.push_back(rec(MagicA)); dir.push_back(rec(MagicB));
        dir.push_back(rec(FmtVersion));
        for (int i = 0; i < 3; i++) dir.push_back(rec(8'h00));
        dir.push_back(rec_st(8'hFF, ST_ID));
        foreach (dir[i]) send_checked(dir[i]);
        drain();

        apb_write(RegDictId, 32'hFFFF_FFFF);
        apb_write(RegCount, 32'd1);
        apb_write(RegMaxOut, 32'd0);
        // Output limit at zero: any phrase expansion fails.
        send_record(1'b1, 1);
        // Declared length that still continues at its tenth byte.
        dir.delete();
        dir.push_back(rec(MagicA)); dir.push_back(rec(MagicB)); dir.push_back(rec(FmtVersion));
        for (int i = 0; i < 4; i++) dir.push_back(rec(8'hFF));
        for (int i = 0; i < 10; i++) dir.push_back(rec(8'hFF));
        dir.push_back(rec_st(8'h01, ST_VARINT));
        foreach (dir[i]) send_checked(dir[i]);
        drain();

        // Count above the phrase table: code 257 is out of range.
        apb_write(RegCount, 32'd511);
        apb_write(RegMaxOut, 32'hFFFF_FFFF);
        dir.delete();
        dir.push_back(rec(MagicA)); dir.push_back(rec(MagicB)); dir.push_back(rec(FmtVersion));
        for (int i = 0; i < 4; i++) dir.push_back(rec(8'hFF));
        dir.push_back(rec(8'd0));
        dir.push_back(rec(8'h81));
        dir.push_back(rec(8'h02));
        dir.push_back(rec_st(8'd0, ST_CODE));
        foreach (dir[i]) send_checked(dir[i]);
        drain();

        // Random part, phased idling; a handful of phrases loaded up front.
        apb_write(RegCount, 32'd4);
        for (int p = 1; p < 4; p++) load_phrase(p, $urandom_range(8, 1));
        items = 0;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                3: begin idle_pct = 36; stall_pct = 36; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            if (phase == 4) begin
                // Long receiver hold-off while the sender keeps offering.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int r = 0; r < 2; r++) begin
                send_record($urandom_range(3) != 0, 4);
                if ($urandom_range(7) == 0) send_item(rec(8'($urandom), 1'b1));
            end
            // Sender pauses until every result is in; then, in phases 2 and 3, switch a register.
            drain();
            if (phase == 2) apb_write(RegMaxOut, 32'd20);
            if (phase == 3) apb_write(RegMaxOut, 32'hFFFF_FFFF);
        end

        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("dictionary_phrase_decoder_test: PASS");
        else
            $display("dictionary_phrase_decoder_test: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
